@@ rtl/cde_pkg.sv @@
`timescale 1ns / 1ps

package cde_pkg;

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;
  localparam logic [2:0] OP_RESIZE     = 3'd5;
  localparam logic [2:0] OP_CLEAR      = 3'd6;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned COUNT_W = 7;

  // broadcast controls for the cell row
  typedef struct packed {
    logic head_ins;      // every cell takes its left neighbor
    logic head_del;      // every cell takes its right neighbor
    logic load_shadow;   // snapshot data into the read chain
    logic shift_shadow;  // read chain moves one cell toward the front
  } cde_ctl_t;

endpackage

@@ rtl/cde_cell.sv @@
`timescale 1ns / 1ps

module cde_cell import cde_pkg::*; #(
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  cde_ctl_t      ctl,
  input  logic          wr_en,
  input  logic [DW-1:0] wr_data,
  input  logic [DW-1:0] left_data,
  input  logic [DW-1:0] right_data,
  input  logic [DW-1:0] right_shadow,
  output logic [DW-1:0] data_o,
  output logic [DW-1:0] shadow_o
);

  logic [DW-1:0] data_r;
  logic [DW-1:0] shadow_r;

  always_ff @(posedge clk) begin
    priority if (ctl.head_ins) begin
      data_r <= left_data;
    end else if (ctl.head_del) begin
      data_r <= right_data;
    end else if (wr_en) begin
      data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctl.load_shadow) begin
      shadow_r <= data_r;
    end else if (ctl.shift_shadow) begin
      shadow_r <= right_shadow;
    end
  end

  assign data_o   = data_r;
  assign shadow_o = shadow_r;

endmodule

@@ rtl/circular_deque_engine_top.sv @@
`timescale 1ns / 1ps

// Double-ended queue built as a row of DEPTH cells; the front element always
// sits in cell 0 and element i in cell i.
// Input channel in_*: one word per operation (push back/front, pop back/front,
// read by signed index, resize, clear). Result channel out_*: one word per
// input word, in order, carrying ok, the read data, the count after the
// operation and the empty/full flags.
// Push, pop, resize and clear finish in the accept cycle: the result is
// registered and the next word can be taken in the next cycle unless the
// spare slot is full. Front pushes and pops shift the whole row by one cell;
// a growing resize writes the value into all new cells at once.
// A read of element k snapshots the row into a second shift chain and walks
// it k steps toward cell 0; the result is taken from cell 0 of that chain,
// and the input is held off during the walk.
// Results go to an output register backed by one spare slot, so a word can
// still be taken while a result waits; once the spare slot fills, in_tready
// drops until out_tready drains it.
// Reset (rst_n low, synchronous) empties the queue and both result slots; the
// cell contents are not cleared and need no clearing pass.
module circular_deque_engine_top import cde_pkg::*; #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // value[31:0], position[38:32], new_size[45:39]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // data[31:0], count[38:32], is_empty[39], is_full[40]
  output logic [0:0]  out_tuser   // ok[0]
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned WW = (CW > SIZE_W) ? CW : SIZE_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] data;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
  } res_t;

  logic [2:0]         op;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   position;
  logic [SIZE_W-1:0]  new_size;

  assign op       = in_tuser;
  assign value    = in_tdata[31:0];
  assign position = in_tdata[38:32];
  assign new_size = in_tdata[45:39];

  logic          state_r;
  logic [CW-1:0] count_r;
  logic [IW-1:0] rem_r;
  logic          out_valid_r;
  logic          pend_valid_r;
  res_t          out_r;
  res_t          pend_r;

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE) && !pend_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  cde_ctl_t             ctl;
  logic                 wr_act;
  logic [WW-1:0]        wr_hi;
  logic [CW-1:0]        cnt_nxt;
  logic                 acc_ok;
  logic                 go_walk;
  logic [IW-1:0]        walk_k;
  logic [POS_W-1:0]     mag;
  logic                 res_valid;
  res_t                 res;
  logic [DATA_WIDTH-1:0] wr_data;

  logic [DATA_WIDTH-1:0] data_w   [DEPTH];
  logic [DATA_WIDTH-1:0] shadow_w [DEPTH];
  logic                  wr_en    [DEPTH];

  assign wr_data = DATA_WIDTH'(value);
  assign mag     = POS_W'(~position + 1'b1);  // magnitude of a negative index

  logic full;
  assign full = (count_r == CW'(DEPTH));

  always_comb begin
    ctl     = '0;
    wr_act  = 1'b0;
    wr_hi   = WW'(count_r) + 1'b1;
    cnt_nxt = count_r;
    acc_ok  = 1'b0;
    go_walk = 1'b0;
    walk_k  = '0;
    if (in_acc) begin
      unique case (op)
        OP_PUSH_BACK: begin
          if (!full) begin
            wr_act  = 1'b1;
            cnt_nxt = count_r + 1'b1;
            acc_ok  = 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          if (!full) begin
            ctl.head_ins = 1'b1;
            cnt_nxt      = count_r + 1'b1;
            acc_ok       = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (count_r != '0) begin
            cnt_nxt = count_r - 1'b1;
            acc_ok  = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (count_r != '0) begin
            ctl.head_del = 1'b1;
            cnt_nxt      = count_r - 1'b1;
            acc_ok       = 1'b1;
          end
        end
        OP_READ: begin
          if (!position[POS_W-1]) begin
            if (WW'(position) < WW'(count_r)) begin
              go_walk = 1'b1;
              walk_k  = IW'(position);
            end
          end else if (WW'(mag) <= WW'(count_r)) begin
            go_walk = 1'b1;
            walk_k  = IW'(count_r - CW'(mag));
          end
          ctl.load_shadow = go_walk;
        end
        OP_RESIZE: begin
          if (WW'(new_size) <= WW'(DEPTH)) begin
            wr_act  = 1'b1;
            wr_hi   = WW'(new_size);
            cnt_nxt = CW'(new_size);
            acc_ok  = 1'b1;
          end
        end
        OP_CLEAR: begin
          cnt_nxt = '0;
          acc_ok  = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (state_r == ST_WALK && rem_r != '0) begin
      ctl.shift_shadow = 1'b1;
    end
  end

  // result of this cycle: an operation that ends at accept, or a finished walk
  always_comb begin
    res_valid    = 1'b0;
    res.ok       = acc_ok;
    res.data     = '0;
    res.count    = COUNT_W'(cnt_nxt);
    res.is_empty = (cnt_nxt == '0);
    res.is_full  = (cnt_nxt == CW'(DEPTH));
    if (state_r == ST_WALK) begin
      if (rem_r == '0) begin
        res_valid = 1'b1;
        res.ok    = 1'b1;
        res.data  = VALUE_W'(shadow_w[0]);
      end
    end else if (in_acc && !go_walk) begin
      res_valid = 1'b1;
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;
      logic [DATA_WIDTH-1:0] right_s;

      if (i == 0) begin : g_first
        assign left_d = wr_data;
      end else begin : g_mid
        assign left_d = data_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_d = data_w[i];
        assign right_s = shadow_w[i];
      end else begin : g_inner
        assign right_d = data_w[i+1];
        assign right_s = shadow_w[i+1];
      end

      assign wr_en[i] = wr_act && (WW'(i) >= WW'(count_r)) && (WW'(i) < wr_hi);

      cde_cell #(
        .DW(DATA_WIDTH)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .wr_en       (wr_en[i]),
        .wr_data     (wr_data),
        .left_data   (left_d),
        .right_data  (right_d),
        .right_shadow(right_s),
        .data_o      (data_w[i]),
        .shadow_o    (shadow_w[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      rem_r   <= '0;
    end else begin
      count_r <= cnt_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (go_walk) begin
            state_r <= ST_WALK;
            rem_r   <= walk_k;
          end
        end
        ST_WALK: begin
          if (rem_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            rem_r <= rem_r - 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output register plus one spare slot
  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (out_free) begin
      if (pend_valid_r) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      pend_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid_r) begin
        out_r <= pend_r;
      end else if (res_valid) begin
        out_r <= res;
      end
    end else if (res_valid) begin
      pend_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.is_full, out_r.is_empty, out_r.count, out_r.data};
  assign out_tuser  = out_r.ok;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(count_r) <= WW'(DEPTH))
    else $error("element count above capacity");

  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == ST_IDLE) && out_valid_r)
    else $error("spare result slot filled outside idle or ahead of output");

  a_row_ops: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.head_ins, ctl.head_del, wr_act, ctl.load_shadow}))
    else $error("conflicting cell row operations");

  a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && rem_r == '0) |=> (state_r == ST_IDLE))
    else $error("read walk did not finish");

endmodule
